// ===== hdl/ibs_pkg.sv =====
package ibs_pkg;
	localparam int DepthDefault = 64;
	localparam int ValueWidth = 32;

	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_RD    = 6'b000010,
		ST_CMP   = 6'b000100,
		ST_EMITR = 6'b001000,
		ST_EMIT  = 6'b010000,
		ST_WAIT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;
endpackage

// ===== hdl/integer_block_sorter_top.sv =====
// channel | signals                                  | direction
// in      | in_valid, in_stall, value, last          | into block
// out     | out_valid, out_stall, sorted_value,      | out of block
//         | end_of_block, dropped                    |
// Loading: one beat per cycle, written straight into the value memory while it has room.
// Sort: insertion sort; each key is read and captured, then each compare/shift reads entry j-1,
// compares it with the key and writes the larger at j; a key that reaches entry 0 is written there.
// Emit: each result is read, captured and then handed over (read, capture, handshake).
// Reset (arst_n low) empties the block; in_stall is high from the last beat until the
// final result is taken; out_stall holds the current result and the sorter waits.
module integer_block_sorter_top #(
	parameter int DEPTH = ibs_pkg::DepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] value,
	input  logic last,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] sorted_value,
	output logic end_of_block,
	output logic dropped
);
	import ibs_pkg::*;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q;
	logic [CW-1:0] fill_q, i_q, j_q, k_q;
	logic ovf_q;
	logic key_ok_q;
	logic signed [31:0] key_q;
	mem_ctl_t ctl;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata, rdata;
	logic acc;

	assign in_stall = (state_q != ST_LOAD);
	assign acc = in_valid && !in_stall;

	ibs_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk(clk), .ctl(ctl), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// j_q is the hole; once the key is held, entry j-1 is compared with it
	always_comb begin
		ctl = '0;
		waddr = fill_q[AW-1:0];
		wdata = value;
		raddr = AW'(j_q - CW'(1));
		case (state_q)
			ST_LOAD: ctl.we = acc && (fill_q < CW'(DEPTH));
			ST_RD: begin
				if (key_ok_q) begin
					if (j_q == '0) begin
						waddr = '0;
						wdata = key_q;
						ctl.we = 1'b1;
					end else begin
						ctl.re = 1'b1;
					end
				end else if (i_q < fill_q) begin
					raddr = i_q[AW-1:0];
					ctl.re = 1'b1;
				end
			end
			ST_CMP: begin
				if (key_ok_q) begin
					waddr = j_q[AW-1:0];
					ctl.we = 1'b1;
					if ($signed(rdata) > key_q) wdata = rdata;
					else wdata = key_q;
				end
			end
			ST_EMITR: begin
				raddr = k_q[AW-1:0];
				ctl.re = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q <= '0;
			ovf_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			key_ok_q <= 1'b0;
			key_q <= '0;
			out_valid <= 1'b0;
			sorted_value <= '0;
			end_of_block <= 1'b0;
			dropped <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: if (acc) begin
					if (fill_q < CW'(DEPTH)) fill_q <= fill_q + CW'(1);
					else ovf_q <= 1'b1;
					if (last) begin
						state_q <= ST_RD;
						i_q <= CW'(1);
						j_q <= CW'(1);
						k_q <= '0;
						key_ok_q <= 1'b0;
					end
				end
				ST_RD: begin
					if (key_ok_q) begin
						if (j_q == '0) begin
							i_q <= i_q + CW'(1);
							key_ok_q <= 1'b0;
						end else begin
							state_q <= ST_CMP;
						end
					end else if (i_q >= fill_q) begin
						state_q <= ST_EMITR;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_RD;
					if (!key_ok_q) begin
						key_q <= rdata;
						key_ok_q <= 1'b1;
						j_q <= i_q;
					end else if ($signed(rdata) > key_q) begin
						j_q <= j_q - CW'(1);
					end else begin
						i_q <= i_q + CW'(1);
						key_ok_q <= 1'b0;
					end
				end
				ST_EMITR: state_q <= ST_EMIT;
				ST_EMIT: begin
					out_valid <= 1'b1;
					sorted_value <= rdata;
					end_of_block <= (k_q + CW'(1) == fill_q);
					dropped <= ovf_q;
					state_q <= ST_WAIT;
				end
				ST_WAIT: if (!out_stall) begin
					out_valid <= 1'b0;
					if (k_q + CW'(1) == fill_q) begin
						fill_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_LOAD;
					end else begin
						k_q <= k_q + CW'(1);
						state_q <= ST_EMITR;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	a_no_out_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> !out_valid) else $error("output during load");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH)) else $error("fill overrun");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sorted_value))
		else $error("result changed under stall");
endmodule

// ===== hdl/ibs_mem.sv =====
module ibs_mem #(
	parameter int DEPTH = ibs_pkg::DepthDefault,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic clk,
	input  ibs_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0] waddr,
	input  logic [ibs_pkg::ValueWidth-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [ibs_pkg::ValueWidth-1:0] rdata
);
	import ibs_pkg::*;
	logic [ValueWidth-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (ctl.we) mem[waddr] <= wdata;
		if (ctl.re) rdata <= mem[raddr];
	end
endmodule
